[design/nbv_pkg.sv]
package nbv_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SHOW_NONPRINTING = 2'd0;
	localparam logic [1:0] REG_SHOW_TABS        = 2'd1;
	localparam logic [1:0] REG_SHOW_ENDS        = 2'd2;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_DOLLAR = 8'd36;
	localparam logic [7:0] CH_MINUS  = 8'd45;
	localparam logic [7:0] CH_QUERY  = 8'd63;
	localparam logic [7:0] CH_M      = 8'd77;
	localparam logic [7:0] CH_CARET  = 8'd94;
	localparam logic [7:0] CH_DEL    = 8'd127;
	localparam logic [7:0] CH_HI_SP  = 8'd160;
	localparam logic [7:0] CH_HI_DEL = 8'd255;
	localparam logic [7:0] CARET_OFS = 8'd64;
	localparam logic [7:0] META_OFS  = 8'd128;

	// most output bytes one item can cause
	localparam int unsigned REC_BYTES = 4;
	localparam int unsigned QUEUE_DEPTH = 4;

	// one expanded item, bytes in output order
	typedef struct packed {
		logic [REC_BYTES-1:0][7:0] bytes;
		logic [1:0]                last_idx;
	} rec_t;

	// configuration write
	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic       data;
	} cfg_wr_t;

endpackage

[design/nonprinting_byte_visualizer_top.sv]
// Turns a byte stream into visible text: caret notation for control bytes,
// M- notation for high bytes, ^I for tab and $ before newlines as the three
// mode registers select, with a carriage return held for one byte of
// lookahead in the plain modes. Each item (a data byte or an end command)
// expands to zero to four result bytes, the final one flagged by last. The
// front end takes one item per cycle while the queue is not full and places
// its expansion in a four-entry record queue; the back end delivers one byte
// per cycle while pop is held. A long expansion holds the back end until its
// last byte is popped, so such items slow the input, with the queue absorbing
// bursts. A pushed item reaches the output through a queue entry and then the
// record register. Configuration writes are always ready and must be made
// only while the block is idle.
module nonprinting_byte_visualizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       cmd,
	input  logic [7:0] in_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data
);
	import nbv_pkg::*;

	cfg_wr_t cfg_wr;
	rec_t    f_rec, q_rec;
	logic    f_valid, q_nonempty, q_rd, accept;

	assign cfg_ready = 1'b1;
	assign cfg_wr = '{valid: cfg_valid, index: cfg_index, data: cfg_data};
	assign accept = push && !full;

	// classifier
	nbv_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_wr(cfg_wr), .accept(accept),
		.cmd(cmd), .in_byte(in_byte), .rec_valid(f_valid), .rec(f_rec)
	);

	// record queue
	nbv_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(f_valid), .wr_rec(f_rec),
		.full(full), .rd_en(q_rd), .nonempty(q_nonempty), .rd_rec(q_rec)
	);

	// byte serialiser
	nbv_back u_back (
		.clk(clk), .arst_n(arst_n), .q_nonempty(q_nonempty), .q_rec(q_rec),
		.q_rd(q_rd), .empty(empty), .pop(pop), .out_byte(out_byte), .last(last)
	);

endmodule

[design/nbv_front.sv]
module nbv_front (
	input  logic            clk,
	input  logic            arst_n,
	input  nbv_pkg::cfg_wr_t cfg_wr,
	input  logic            accept,
	input  logic            cmd,
	input  logic [7:0]      in_byte,
	output logic            rec_valid,
	output nbv_pkg::rec_t   rec
);
	import nbv_pkg::*;

	logic show_np_q, show_tabs_q, show_ends_q, cr_held_q;
	logic [1:0][7:0] lb_bytes;
	logic [1:0]      lb_cnt;
	logic [1:0][7:0] pre_bytes;
	logic [1:0]      pre_cnt;
	logic [3:0][7:0] body;
	logic [2:0]      body_cnt;
	logic            set_cr;
	logic [2:0]      total;
	logic [1:0]      sel;

	// line break with optional end marker
	always_comb begin
		if (show_ends_q) begin
			lb_bytes = {CH_LF, CH_DOLLAR};
			lb_cnt = 2'd2;
		end else begin
			lb_bytes = {8'd0, CH_LF};
			lb_cnt = 2'd1;
		end
	end

	// held carriage return resolved ahead of this item
	always_comb begin
		if (cr_held_q && (cmd || in_byte != CH_LF)) begin
			pre_bytes = lb_bytes;
			pre_cnt = lb_cnt;
		end else begin
			pre_bytes = '0;
			pre_cnt = 2'd0;
		end
	end

	// classify the byte itself
	always_comb begin
		body = '0;
		body_cnt = 3'd0;
		set_cr = 1'b0;
		if (!cmd) begin
			if (show_np_q) begin
				if (in_byte >= CH_SPACE) begin
					if (in_byte < CH_DEL) begin
						body[0] = in_byte;
						body_cnt = 3'd1;
					end else if (in_byte == CH_DEL) begin
						body[0] = CH_CARET;
						body[1] = CH_QUERY;
						body_cnt = 3'd2;
					end else begin
						body[0] = CH_M;
						body[1] = CH_MINUS;
						if (in_byte >= CH_HI_SP) begin
							if (in_byte < CH_HI_DEL) begin
								body[2] = in_byte - META_OFS;
								body_cnt = 3'd3;
							end else begin
								body[2] = CH_CARET;
								body[3] = CH_QUERY;
								body_cnt = 3'd4;
							end
						end else begin
							body[2] = CH_CARET;
							body[3] = in_byte - CARET_OFS;
							body_cnt = 3'd4;
						end
					end
				end else if (in_byte == CH_TAB && !show_tabs_q) begin
					body[0] = in_byte;
					body_cnt = 3'd1;
				end else if (in_byte == CH_LF) begin
					body[1:0] = lb_bytes;
					body_cnt = {1'b0, lb_cnt};
				end else begin
					body[0] = CH_CARET;
					body[1] = in_byte + CARET_OFS;
					body_cnt = 3'd2;
				end
			end else if (show_tabs_q || show_ends_q) begin
				if (in_byte == CH_TAB && show_tabs_q) begin
					body[0] = CH_CARET;
					body[1] = in_byte + CARET_OFS;
					body_cnt = 3'd2;
				end else if (in_byte == CH_CR) begin
					body[0] = CH_CARET;
					body[1] = CH_M;
					body_cnt = 3'd2;
					set_cr = 1'b1;
				end else if (in_byte == CH_LF) begin
					body[1:0] = lb_bytes;
					body_cnt = {1'b0, lb_cnt};
				end else begin
					body[0] = in_byte;
					body_cnt = 3'd1;
				end
			end else begin
				body[0] = in_byte;
				body_cnt = 3'd1;
			end
		end
	end

	// pack prefix and body into one record
	always_comb begin
		total = {1'b0, pre_cnt} + body_cnt;
		rec.last_idx = 2'(total - 3'd1);
		sel = 2'd0;
		for (int k = 0; k < REC_BYTES; k++) begin
			sel = 2'(k) - pre_cnt;
			if (2'(k) < pre_cnt && k < 2) begin
				rec.bytes[k] = pre_bytes[k[0]];
			end else begin
				rec.bytes[k] = body[sel];
			end
		end
		rec_valid = accept && (total != 3'd0);
	end

	// mode registers and carriage return state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_np_q <= 1'b0;
			show_tabs_q <= 1'b0;
			show_ends_q <= 1'b0;
			cr_held_q <= 1'b0;
		end else begin
			if (cfg_wr.valid) begin
				case (cfg_wr.index)
					REG_SHOW_NONPRINTING: begin
						show_np_q <= cfg_wr.data;
						if (cfg_wr.data) cr_held_q <= 1'b0;
					end
					REG_SHOW_TABS: show_tabs_q <= cfg_wr.data;
					REG_SHOW_ENDS: show_ends_q <= cfg_wr.data;
					default: ;
				endcase
			end
			if (accept) begin
				cr_held_q <= set_cr;
			end
		end
	end

endmodule

[design/nbv_queue.sv]
module nbv_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  nbv_pkg::rec_t wr_rec,
	output logic          full,
	input  logic          rd_en,
	output logic          nonempty,
	output nbv_pkg::rec_t rd_rec
);
	import nbv_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	rec_t              mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       cnt_q;

	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_rec = mem_q[rd_ptr_q];

	// record storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[design/nbv_back.sv]
module nbv_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  nbv_pkg::rec_t q_rec,
	output logic          q_rd,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          last
);
	import nbv_pkg::*;

	rec_t       rec_q;
	logic [1:0] idx_q;
	logic       valid_q;
	logic       take, fin;

	// current byte of the record in hand
	assign empty = !valid_q;
	assign out_byte = rec_q.bytes[idx_q];
	assign last = (idx_q == rec_q.last_idx);
	assign take = pop && valid_q;
	assign fin = take && last;
	assign q_rd = q_nonempty && (!valid_q || fin);

	// record register
	always_ff @(posedge clk) begin
		if (q_rd) rec_q <= q_rec;
	end

	// byte index and valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			idx_q <= '0;
		end else if (fin) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import nbv_pkg::*;

	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;
	localparam int   STALL_LIMIT = 2000;
	localparam int   SETTLE_CYCLES = 8;

	typedef struct packed {
		logic       cmd;
		logic [7:0] ch;
	} raw_item_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} shown_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       cmd = CMD_DATA;
	logic [7:0] in_byte = 8'd0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = REG_SHOW_NONPRINTING;
	logic       cfg_data = 1'b0;

	// items waiting for the driver, bytes waiting for the block
	raw_item_t   raw_items[$];
	shown_byte_t shown_due[$];
	logic [7:0]  scratch[$];

	// predictor copy of the mode registers and the held carriage return
	logic mode_np = 1'b0;
	logic mode_tabs = 1'b0;
	logic mode_ends = 1'b0;
	logic cr_pending = 1'b0;

	int  mismatch_count = 0;
	int  items_taken = 0;
	int  items_offered = 0;
	int  results_seen = 0;
	int  cfg_seen = 0;
	int  idle_run = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_stage = 0;
	logic calm = 1'b0;
	logic took;

	logic [7:0] corner_bytes [10] = '{8'd0, 8'd31, 8'd32, 8'd126, 8'd127,
		8'd128, 8'd159, 8'd160, 8'd254, 8'd255};

	nonprinting_byte_visualizer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.in_byte   (in_byte),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	task automatic note_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void add_break();
		if (mode_ends)
			scratch.push_back(CH_DOLLAR);
		scratch.push_back(CH_LF);
	endfunction

	// expand one accepted item into the bytes it should show
	function automatic void render_item(input raw_item_t it);
		logic [7:0] c;
		c = it.ch;
		scratch.delete();
		if (it.cmd == CMD_END) begin
			if (cr_pending)
				add_break();
			cr_pending = 1'b0;
		end else begin
			// held carriage return resolved by lookahead
			if (cr_pending) begin
				cr_pending = 1'b0;
				if (c != CH_LF)
					add_break();
			end
			if (mode_np) begin
				if (c >= CH_SPACE && c < CH_DEL) begin
					scratch.push_back(c);
				end else if (c == CH_DEL) begin
					scratch.push_back(CH_CARET);
					scratch.push_back(CH_QUERY);
				end else if (c >= META_OFS) begin
					scratch.push_back(CH_M);
					scratch.push_back(CH_MINUS);
					if (c >= CH_HI_SP && c < CH_HI_DEL) begin
						scratch.push_back(c - META_OFS);
					end else if (c == CH_HI_DEL) begin
						scratch.push_back(CH_CARET);
						scratch.push_back(CH_QUERY);
					end else begin
						scratch.push_back(CH_CARET);
						scratch.push_back(c - CARET_OFS);
					end
				end else if (c == CH_TAB && !mode_tabs) begin
					scratch.push_back(c);
				end else if (c == CH_LF) begin
					add_break();
				end else begin
					scratch.push_back(CH_CARET);
					scratch.push_back(c + CARET_OFS);
				end
			end else if (mode_tabs || mode_ends) begin
				if (c == CH_TAB && mode_tabs) begin
					scratch.push_back(CH_CARET);
					scratch.push_back(c + CARET_OFS);
				end else if (c == CH_CR) begin
					scratch.push_back(CH_CARET);
					scratch.push_back(CH_M);
					cr_pending = 1'b1;
				end else if (c == CH_LF) begin
					add_break();
				end else begin
					scratch.push_back(c);
				end
			end else begin
				scratch.push_back(c);
			end
		end
		for (int i = 0; i < scratch.size(); i++)
			shown_due.push_back('{ch: scratch[i], fin: (i == scratch.size() - 1)});
	endfunction

	// monitor: config writes, accepted items, accepted results, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			took = 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHOW_NONPRINTING: begin
						mode_np = cfg_data;
						if (cfg_data)
							cr_pending = 1'b0;
					end
					REG_SHOW_TABS: mode_tabs = cfg_data;
					REG_SHOW_ENDS: mode_ends = cfg_data;
					default: ;
				endcase
				cfg_seen++;
				took = 1'b1;
			end
			if (push && !full) begin
				render_item(raw_items.pop_front());
				items_taken++;
				took = 1'b1;
			end
			if (pop && !empty) begin
				if (shown_due.size() == 0) begin
					note_mismatch($sformatf("unexpected byte %0d", out_byte));
				end else begin
					if (out_byte !== shown_due[0].ch)
						note_mismatch($sformatf("out_byte %0d, wanted %0d",
							out_byte, shown_due[0].ch));
					if (last !== shown_due[0].fin)
						note_mismatch($sformatf("last %b, wanted %b on byte %0d",
							last, shown_due[0].fin, shown_due[0].ch));
					void'(shown_due.pop_front());
				end
				results_seen++;
				took = 1'b1;
			end
			idle_run = took ? 0 : idle_run + 1;
			if (idle_run >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// driver: offers queued items, with short random gaps between them
	always @(negedge clk) begin
		if (push && items_taken != items_offered) begin
			// current item not yet taken, keep it on the bus
		end else if (gap_left != 0) begin
			push <= 1'b0;
			gap_left--;
		end else if (raw_items.size() != 0) begin
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 2);
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				cmd <= raw_items[0].cmd;
				in_byte <= raw_items[0].ch;
				items_offered++;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// receiver: random short stalls plus two long hold-offs to fill the block
	always @(negedge clk) begin
		if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (hold_stage < 2 && results_seen >= (hold_stage + 1) * 200) begin
			hold_left = 60;
			hold_stage++;
			pop <= 1'b0;
		end else if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	function automatic void add_item(input logic c, input logic [7:0] b);
		raw_items.push_back('{cmd: c, ch: b});
	endfunction

	function automatic logic [7:0] pick_byte(input logic after_cr);
		if (after_cr && $urandom_range(0, 1) == 0)
			return CH_LF;
		case ($urandom_range(0, 9))
			0: return CH_CR;
			1: return CH_LF;
			2: return CH_TAB;
			3, 4: return corner_bytes[$urandom_range(0, 9)];
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic val);
		int seen;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		seen = cfg_seen;
		do @(negedge clk); while (cfg_seen == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_modes(input logic np, input logic tabs, input logic ends);
		write_reg(REG_SHOW_NONPRINTING, np);
		write_reg(REG_SHOW_TABS, tabs);
		write_reg(REG_SHOW_ENDS, ends);
	endtask

	// wait for every item taken and every byte seen, then let the block settle
	task automatic drain();
		while (raw_items.size() != 0 || shown_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] b;
		logic       prev_cr;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// all modes off straight from reset: everything passes
		add_item(CMD_DATA, 8'd0);
		add_item(CMD_DATA, 8'd255);
		add_item(CMD_DATA, CH_CR);
		add_item(CMD_DATA, CH_LF);
		drain();

		// every mode on: caret and meta forms at the range edges
		set_modes(1'b1, 1'b1, 1'b1);
		foreach (corner_bytes[i])
			add_item(CMD_DATA, corner_bytes[i]);
		add_item(CMD_DATA, CH_TAB);
		add_item(CMD_DATA, CH_LF);
		add_item(CMD_DATA, CH_CR);
		drain();

		// plain mode: held carriage return before newline, other byte, end
		set_modes(1'b0, 1'b1, 1'b1);
		add_item(CMD_DATA, CH_TAB);
		add_item(CMD_DATA, CH_CR);
		add_item(CMD_DATA, CH_LF);
		add_item(CMD_DATA, CH_CR);
		add_item(CMD_DATA, 8'd65);
		add_item(CMD_DATA, CH_CR);
		add_item(CMD_END, 8'd255);
		add_item(CMD_END, 8'd0);
		add_item(CMD_DATA, CH_CR);
		drain();

		// random phases through every mode combination, the last one calm
		for (int k = 0; k < 9; k++) begin
			if (k == 8)
				calm = 1'b1;
			set_modes(k[2] ^ k[0], k[1], k[0] | (k == 8));
			prev_cr = 1'b0;
			for (int n = 0; n < 50; n++) begin
				if ($urandom_range(0, 11) == 0) begin
					add_item(CMD_END, 8'($urandom_range(0, 255)));
					prev_cr = 1'b0;
				end else begin
					b = pick_byte(prev_cr);
					add_item(CMD_DATA, b);
					prev_cr = (b == CH_CR);
				end
			end
			// leave a carriage return held across the next mode change
			if ($urandom_range(0, 1) == 0)
				add_item(CMD_DATA, CH_CR);
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && shown_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[nonprinting_byte_visualizer_top.f]
design/nbv_pkg.sv
design/nbv_front.sv
design/nbv_queue.sv
design/nbv_back.sv
design/nonprinting_byte_visualizer_top.sv
tb/sv/testbench.sv
